// ===== design/quaternion_slerp_core_macros.svh =====
// Assertion helpers used by the quaternion slerp core.
`ifndef QUATERNION_SLERP_CORE_MACROS_SVH
`define QUATERNION_SLERP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define QS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("quaternion slerp check failed");
`define QS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("quaternion slerp sequence check failed");
`else
`define QS_ASSERT(lbl, clk, rst_n, prop)
`define QS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif
`endif

// ===== design/qslerp_pkg.sv =====
package qslerp_pkg;

    localparam int CompBits        = 16;
    localparam int AngleIterations = 16;
    localparam int CordicSteps     = (AngleIterations < 32) ? AngleIterations : 32;
    localparam int SqrtSteps       = 31;
    localparam int DivSteps        = 33;

    localparam logic [31:0] HalfPiQ30   = 32'd1686629713;
    localparam logic [31:0] PiQ30       = 32'd3373259426;
    localparam logic [35:0] CordicGain  = 36'd652032874;
    localparam logic [32:0] WeightLimit = 33'h0FFFFFFFF;
    localparam logic [14:0] ThrReset    = 15'd16376;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
        30'h00000001, 30'h00000000
    };

    typedef struct packed {
        logic signed [CompBits-1:0] a_w;
        logic signed [CompBits-1:0] a_x;
        logic signed [CompBits-1:0] a_y;
        logic signed [CompBits-1:0] a_z;
        logic signed [CompBits-1:0] b_w;
        logic signed [CompBits-1:0] b_x;
        logic signed [CompBits-1:0] b_y;
        logic signed [CompBits-1:0] b_z;
        logic        [14:0]         blend;
    } t_in_word;

    typedef struct packed {
        logic signed [CompBits-1:0] out_w;
        logic signed [CompBits-1:0] out_x;
        logic signed [CompBits-1:0] out_y;
        logic signed [CompBits-1:0] out_z;
        logic                       used_linear;
    } t_out_word;

    typedef struct packed {
        logic [3:0][CompBits:0] qa;
        logic [3:0][CompBits:0] qb;
        logic [14:0]            t;
        logic [30:0]            c;
        logic                   lin;
        logic                   flip;
        logic                   neg;
        logic                   ovf;
        logic [30:0]            sin0;
        logic signed [35:0]     x;
        logic signed [35:0]     y;
        logic signed [35:0]     z;
        logic signed [35:0]     ct;
        logic [63:0]            rem;
        logic [63:0]            acc;
        logic [3:0][50:0]       m0;
        logic [3:0][50:0]       m1;
        logic [3:0][33:0]       lp;
        logic signed [35:0]     s0;
        logic signed [35:0]     s1;
    } t_pipe;

endpackage

// ===== design/qslerp_isqrt.sv =====
module qslerp_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  qslerp_pkg::t_pipe   i_pipe,
    output logic                o_valid,
    output qslerp_pkg::t_pipe   o_pipe
);

    localparam int NS = qslerp_pkg::SqrtSteps;

    qslerp_pkg::t_pipe r_p [NS];
    qslerp_pkg::t_pipe w_n [NS];
    qslerp_pkg::t_pipe w_prev [NS];
    logic [NS-1:0]     r_v;

    for (genvar gs = 0; gs < NS; gs++) begin : g_step
        localparam int K = NS - 1 - gs;
        qslerp_pkg::t_pipe n_p;

        if (gs == 0) begin : g_first
            assign w_prev[gs] = i_pipe;
        end else begin : g_next
            assign w_prev[gs] = r_p[gs-1];
        end

        always_comb begin
            logic [63:0] tv;
            n_p = w_prev[gs];
            tv  = (w_prev[gs].acc << (K + 1)) + (64'd1 << (2 * K));
            if (w_prev[gs].rem >= tv) begin
                n_p.rem = w_prev[gs].rem - tv;
                n_p.acc = w_prev[gs].acc + (64'd1 << K);
            end
        end

        assign w_n[gs] = n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_n;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_pipe  = r_p[NS-1];

endmodule

// ===== design/quaternion_slerp_core.sv =====
// Quaternion slerp, fully pipelined: one word is accepted in every cycle that the output
// side does not stall.
// Between acceptance and the result word lie the 31-step square root, the two 16-step
// angle pipelines and the 33-step weight divider.
// Reset (synchronous, active low) empties the pipeline and loads the threshold with 16376.
`include "quaternion_slerp_core_macros.svh"

module quaternion_slerp_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  qslerp_pkg::t_in_word   i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output qslerp_pkg::t_out_word  o_out_word,
    input  logic                   i_cfg_wr_en,
    input  logic [14:0]            i_cfg_wr_data
);

    localparam int NF   = 5;
    localparam int NI   = qslerp_pkg::CordicSteps;
    localparam int LV0  = 0;
    localparam int LVEC = 1;
    localparam int LTH1 = LVEC + NI;
    localparam int LTH2 = LTH1 + 1;
    localparam int LROT = LTH2 + 1;
    localparam int LDP  = LROT + NI;
    localparam int LDIV = LDP + 1;
    localparam int LS1  = LDIV + qslerp_pkg::DivSteps;
    localparam int LCS  = LS1 + 1;
    localparam int LS0  = LCS + 1;
    localparam int LMUL = LS0 + 1;
    localparam int NB   = LMUL + 1;

    logic        w_en;
    logic        w_in_acc;
    logic [14:0] r_thr;

    qslerp_pkg::t_pipe r_f [NF];
    qslerp_pkg::t_pipe w_nf [NF];
    logic [NF-1:0]     r_fv;

    qslerp_pkg::t_pipe w_sq_p;
    logic              w_sq_v;

    qslerp_pkg::t_pipe r_b [NB];
    qslerp_pkg::t_pipe w_nb [NB];
    qslerp_pkg::t_pipe w_bp [NB];
    logic [NB-1:0]     r_bv;

    qslerp_pkg::t_out_word r_out;
    qslerp_pkg::t_out_word n_out;
    logic                  r_out_vld;

    function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
        if (v > 52'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -52'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    assign w_en        = !r_out_vld || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign w_in_acc    = i_in_valid && w_en;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qslerp_pkg::ThrReset;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    for (genvar gk = 0; gk < NF; gk++) begin : g_front
        qslerp_pkg::t_pipe n_p;

        if (gk == 0) begin : g_cap
            always_comb begin
                n_p       = '0;
                n_p.qa[0] = {i_in_word.a_w[15], i_in_word.a_w};
                n_p.qa[1] = {i_in_word.a_x[15], i_in_word.a_x};
                n_p.qa[2] = {i_in_word.a_y[15], i_in_word.a_y};
                n_p.qa[3] = {i_in_word.a_z[15], i_in_word.a_z};
                n_p.qb[0] = {i_in_word.b_w[15], i_in_word.b_w};
                n_p.qb[1] = {i_in_word.b_x[15], i_in_word.b_x};
                n_p.qb[2] = {i_in_word.b_y[15], i_in_word.b_y};
                n_p.qb[3] = {i_in_word.b_z[15], i_in_word.b_z};
                n_p.t     = i_in_word.blend;
            end
        end else if (gk == 1) begin : g_prod
            always_comb begin
                logic signed [33:0] pr;
                n_p = r_f[gk-1];
                for (int i = 0; i < 4; i++) begin
                    pr          = $signed(r_f[gk-1].qa[i]) * $signed(r_f[gk-1].qb[i]);
                    n_p.m0[i]   = 51'(pr);
                end
            end
        end else if (gk == 2) begin : g_dot
            always_comb begin
                logic signed [35:0] dot;
                logic [35:0]        dabs;
                logic [26:0]        cm;
                n_p = r_f[gk-1];
                dot = '0;
                for (int i = 0; i < 4; i++) begin
                    dot = dot + 36'($signed(r_f[gk-1].m0[i][33:0]) >>> 2);
                end
                n_p.neg = dot[35];
                dabs    = dot[35] ? 36'(-dot) : 36'(dot);
                n_p.lin = dabs > 36'({r_thr, 12'b0});
                cm      = (dabs > 36'd67108864) ? 27'd67108864 : dabs[26:0];
                n_p.c   = {cm, 4'b0};
                for (int i = 0; i < 4; i++) begin
                    if (dot[35]) begin
                        n_p.qb[i] = 17'(-$signed(r_f[gk-1].qb[i]));
                    end
                end
            end
        end else if (gk == 3) begin : g_csq
            always_comb begin
                logic [61:0] cc;
                n_p     = r_f[gk-1];
                cc      = r_f[gk-1].c * r_f[gk-1].c;
                n_p.acc = 64'(cc);
            end
        end else begin : g_rad
            always_comb begin
                n_p     = r_f[gk-1];
                n_p.rem = (64'd1 << 60) - r_f[gk-1].acc;
                n_p.acc = '0;
            end
        end

        assign w_nf[gk] = n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[NF-2:0], w_in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f <= w_nf;
        end
    end

    qslerp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_fv[NF-1]),
        .i_pipe  (r_f[NF-1]),
        .o_valid (w_sq_v),
        .o_pipe  (w_sq_p)
    );

    for (genvar gk = 0; gk < NB; gk++) begin : g_back
        qslerp_pkg::t_pipe n_p;

        if (gk == 0) begin : g_first
            assign w_bp[gk] = w_sq_p;
        end else begin : g_next
            assign w_bp[gk] = r_b[gk-1];
        end

        if (gk == LV0) begin : g_v0
            always_comb begin
                n_p      = w_bp[gk];
                n_p.sin0 = w_bp[gk].acc[30:0];
                n_p.lin  = w_bp[gk].lin || (w_bp[gk].acc[30:0] == 31'd0);
                n_p.x    = 36'(w_bp[gk].c);
                n_p.y    = 36'(w_bp[gk].acc[30:0]);
                n_p.z    = '0;
            end
        end else if (gk >= LVEC && gk < LTH1) begin : g_vec
            localparam int Sh = gk - LVEC;
            always_comb begin
                logic signed [35:0] dx;
                logic signed [35:0] dy;
                logic signed [35:0] at;
                n_p = w_bp[gk];
                dx  = w_bp[gk].y >>> Sh;
                dy  = w_bp[gk].x >>> Sh;
                at  = 36'(qslerp_pkg::ATAN_Q30[Sh]);
                if (!w_bp[gk].y[35]) begin
                    n_p.x = w_bp[gk].x + dx;
                    n_p.y = w_bp[gk].y - dy;
                    n_p.z = w_bp[gk].z + at;
                end else begin
                    n_p.x = w_bp[gk].x - dx;
                    n_p.y = w_bp[gk].y + dy;
                    n_p.z = w_bp[gk].z - at;
                end
            end
        end else if (gk == LTH1) begin : g_th1
            always_comb begin
                logic signed [35:0] half;
                logic [30:0]        th0;
                logic [45:0]        thp;
                n_p  = w_bp[gk];
                half = 36'(qslerp_pkg::HalfPiQ30);
                if (w_bp[gk].z < 36'sd0) begin
                    th0 = '0;
                end else if (w_bp[gk].z > half) begin
                    th0 = qslerp_pkg::HalfPiQ30[30:0];
                end else begin
                    th0 = w_bp[gk].z[30:0];
                end
                thp     = th0 * w_bp[gk].t;
                n_p.acc = 64'(thp);
            end
        end else if (gk == LTH2) begin : g_th2
            always_comb begin
                logic [31:0] th;
                logic [31:0] phi;
                n_p      = w_bp[gk];
                th       = w_bp[gk].acc[45:14];
                n_p.flip = th > qslerp_pkg::HalfPiQ30;
                phi      = n_p.flip ? (qslerp_pkg::PiQ30 - th) : th;
                n_p.x    = $signed(qslerp_pkg::CordicGain);
                n_p.y    = '0;
                n_p.z    = 36'(phi);
            end
        end else if (gk >= LROT && gk < LDP) begin : g_rot
            localparam int Sh = gk - LROT;
            always_comb begin
                logic signed [35:0] dx;
                logic signed [35:0] dy;
                logic signed [35:0] at;
                n_p = w_bp[gk];
                dx  = w_bp[gk].y >>> Sh;
                dy  = w_bp[gk].x >>> Sh;
                at  = 36'(qslerp_pkg::ATAN_Q30[Sh]);
                if (!w_bp[gk].z[35]) begin
                    n_p.x = w_bp[gk].x - dx;
                    n_p.y = w_bp[gk].y + dy;
                    n_p.z = w_bp[gk].z - at;
                end else begin
                    n_p.x = w_bp[gk].x + dx;
                    n_p.y = w_bp[gk].y - dy;
                    n_p.z = w_bp[gk].z + at;
                end
            end
        end else if (gk == LDP) begin : g_dprep
            always_comb begin
                logic [35:0] mag;
                n_p     = w_bp[gk];
                n_p.ct  = w_bp[gk].flip ? -w_bp[gk].x : w_bp[gk].x;
                n_p.neg = w_bp[gk].y[35];
                mag     = w_bp[gk].y[35] ? 36'(-w_bp[gk].y) : 36'(w_bp[gk].y);
                n_p.ovf = mag >= {2'b0, w_bp[gk].sin0, 3'b0};
                n_p.rem = 64'(mag) << 30;
                n_p.acc = '0;
            end
        end else if (gk >= LDIV && gk < LS1) begin : g_div
            localparam int Sh = qslerp_pkg::DivSteps - 1 - (gk - LDIV);
            always_comb begin
                logic [63:0] tv;
                n_p = w_bp[gk];
                tv  = 64'(w_bp[gk].sin0) << Sh;
                if (w_bp[gk].rem >= tv) begin
                    n_p.rem     = w_bp[gk].rem - tv;
                    n_p.acc[Sh] = 1'b1;
                end
            end
        end else if (gk == LS1) begin : g_s1
            always_comb begin
                logic [32:0] mag1;
                n_p = w_bp[gk];
                if (w_bp[gk].ovf || (w_bp[gk].acc[32:0] > qslerp_pkg::WeightLimit)) begin
                    mag1 = qslerp_pkg::WeightLimit;
                end else begin
                    mag1 = w_bp[gk].acc[32:0];
                end
                n_p.s1 = w_bp[gk].neg ? -$signed(36'(mag1)) : $signed(36'(mag1));
            end
        end else if (gk == LCS) begin : g_cs
            always_comb begin
                logic [47:0]        clo;
                logic signed [50:0] chi;
                n_p       = w_bp[gk];
                clo       = w_bp[gk].c * w_bp[gk].s1[16:0];
                chi       = $signed({1'b0, w_bp[gk].c}) * $signed(w_bp[gk].s1[35:17]);
                n_p.m0[0] = 51'(clo);
                n_p.m0[1] = chi;
            end
        end else if (gk == LS0) begin : g_s0
            always_comb begin
                logic signed [67:0] prod;
                logic signed [67:0] s0raw;
                logic signed [67:0] lim;
                n_p   = w_bp[gk];
                lim   = 68'(qslerp_pkg::WeightLimit);
                prod  = (68'($signed(w_bp[gk].m0[1])) <<< 17) + 68'(w_bp[gk].m0[0][47:0]);
                s0raw = 68'(w_bp[gk].ct) - (prod >>> 30);
                if (s0raw > lim) begin
                    n_p.s0 = 36'(lim);
                end else if (s0raw < -lim) begin
                    n_p.s0 = 36'(-lim);
                end else begin
                    n_p.s0 = 36'(s0raw);
                end
            end
        end else begin : g_mul
            always_comb begin
                logic signed [50:0] ma;
                logic signed [50:0] mb;
                logic signed [17:0] diff;
                logic signed [33:0] lpv;
                n_p  = w_bp[gk];
                for (int i = 0; i < 4; i++) begin
                    ma        = $signed(w_bp[gk].s0[33:0]) * $signed(w_bp[gk].qa[i]);
                    mb        = $signed(w_bp[gk].s1[33:0]) * $signed(w_bp[gk].qb[i]);
                    diff      = 18'($signed(w_bp[gk].qb[i])) - 18'($signed(w_bp[gk].qa[i]));
                    lpv       = $signed({1'b0, w_bp[gk].t}) * diff;
                    n_p.m0[i] = ma;
                    n_p.m1[i] = mb;
                    n_p.lp[i] = lpv;
                end
            end
        end

        assign w_nb[gk] = n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_en) begin
            r_bv <= {r_bv[NB-2:0], w_sq_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b <= w_nb;
        end
    end

    always_comb begin
        logic signed [51:0]   v;
        logic signed [15:0]   res [4];
        for (int i = 0; i < 4; i++) begin
            if (r_b[NB-1].lin) begin
                v = 52'($signed(r_b[NB-1].qa[i]))
                    + 52'(($signed(r_b[NB-1].lp[i]) + 34'sd8192) >>> 14);
            end else begin
                v = (52'($signed(r_b[NB-1].m0[i])) >>> 2)
                    + (52'($signed(r_b[NB-1].m1[i])) >>> 2) + 52'sd134217728;
                v = v >>> 28;
            end
            res[i] = sat16(v);
        end
        n_out.out_w       = res[0];
        n_out.out_x       = res[1];
        n_out.out_y       = res[2];
        n_out.out_z       = res[3];
        n_out.used_linear = r_b[NB-1].lin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_bv[NB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    `QS_ASSERT(a_zero_sine_linear, i_clk, i_rst_n, r_bv[LV0] && (r_b[LV0].sin0 == 31'd0) |-> r_b[LV0].lin)
    `QS_ASSERT(a_div_remainder, i_clk, i_rst_n, r_bv[LS1-1] && !r_b[LS1-1].ovf |-> r_b[LS1-1].rem < 64'(r_b[LS1-1].sin0))
    `QS_ASSERT(a_out_from_pipe, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_bv[NB-1]))
    `QS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_bv) && $stable(r_fv))

endmodule
